/* sv/bqdf1_pkg.sv */
// Shared types, constants and coefficient table for the biquad cascade.
package bqdf1_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int CSR_WIDTH    = 4;
   localparam int ROM_STAGES   = 10;
   localparam logic [CSR_WIDTH-1:0] STAGES_RESET = CSR_WIDTH'(10);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      sample_type sample_in;
      logic       block_end;
   } req_type;

   typedef struct packed {
      sample_type sample_out;
      logic       block_end_out;
   } rsp_type;

   // word handed from one section to the next
   typedef struct packed {
      logic       valid;
      sample_type sample;
   } link_type;

   typedef enum logic [2:0] {
      TAP_B0,
      TAP_B1,
      TAP_B2,
      TAP_A1,
      TAP_A2
   } tap_type;

   // Decimal coefficients scaled by 1e12; converted to Q2.30 below.
   localparam longint QC_SCALE = 64'sd524288;
   localparam longint QC_HALF  = 64'sd244140625;
   localparam longint QC_DEN   = 64'sd488281250;

   localparam longint B_M [ROM_STAGES] = '{
      64'sd466130702185, 64'sd466130702185, 64'sd422508537540, 64'sd422508537540,
      64'sd343789366023, 64'sd343789366023, 64'sd232050049640, 64'sd232050049640,
      64'sd105034408654, 64'sd105034408654
   };

   localparam longint A1_M [ROM_STAGES] = '{
      64'sd1093487650431, 64'sd1999977686300, 64'sd1178427121117, 64'sd1999921389117,
      64'sd1354288476075, 64'sd1999808871051, 64'sd1557102476250, 64'sd1999448839071,
      64'sd1996949476254, 64'sd1698170578807
   };

   localparam longint A2_M [ROM_STAGES] = '{
      64'sd963409689322, 64'sd999977928207, 64'sd893306363478, 64'sd999921684910,
      64'sd827899867908, 64'sd999809333555, 64'sd773298891409, 64'sd999449899257,
      64'sd996954813773, 64'sd742479595442
   };

   function automatic longint qc(input longint m);
      return (m * QC_SCALE + QC_HALF) / QC_DEN;
   endfunction

   // Coefficient of one tap, rounded to cw bits and saturated at the positive limit.
   function automatic longint coef_word(input int stage, input tap_type tap, input int cw);
      longint c;
      longint top;
      int     s;
      case (tap)
         TAP_B0:  c = qc(B_M[stage]);
         TAP_B1:  c = 64'sd0;
         TAP_B2:  c = -qc(B_M[stage]);
         TAP_A1:  c = qc(A1_M[stage]);
         TAP_A2:  c = -qc(A2_M[stage]);
         default: c = 64'sd0;
      endcase
      s = 32 - cw;
      if (s > 0) begin
         c   = (c + (64'sd1 <<< (s - 1))) >>> s;
         top = (64'sd1 <<< (cw - 1)) - 64'sd1;
         if (c > top) begin
            c = top;
         end
      end
      return c;
   endfunction

endpackage

/* sv/bqdf1_section.sv */
// One second-order section: history, multipliers, round, saturate; or pass-through.
module bqdf1_section #(
   parameter int STAGE       = 0,
   parameter int COEFF_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                active,
   input  bqdf1_pkg::link_type link_in,
   output bqdf1_pkg::link_type link_out
);
   import bqdf1_pkg::*;

   localparam int PW    = SAMPLE_WIDTH + COEFF_WIDTH;
   localparam int AW    = PW + 3;
   localparam int SHIFT = COEFF_WIDTH - 2;
   localparam int RW    = AW - SHIFT;

   link_type out_ff;
   link_type out_in;

   assign link_out = out_ff;

   always_ff @(posedge clock) begin
      out_ff.sample <= out_in.sample;
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
   end

   generate
      if (STAGE < ROM_STAGES) begin : g_iir
         localparam logic signed [COEFF_WIDTH-1:0] C_B0 =
            COEFF_WIDTH'(coef_word(STAGE, TAP_B0, COEFF_WIDTH));
         localparam logic signed [COEFF_WIDTH-1:0] C_B1 =
            COEFF_WIDTH'(coef_word(STAGE, TAP_B1, COEFF_WIDTH));
         localparam logic signed [COEFF_WIDTH-1:0] C_B2 =
            COEFF_WIDTH'(coef_word(STAGE, TAP_B2, COEFF_WIDTH));
         localparam logic signed [COEFF_WIDTH-1:0] C_A1 =
            COEFF_WIDTH'(coef_word(STAGE, TAP_A1, COEFF_WIDTH));
         localparam logic signed [COEFF_WIDTH-1:0] C_A2 =
            COEFF_WIDTH'(coef_word(STAGE, TAP_A2, COEFF_WIDTH));
         localparam logic [AW-1:0] ROUND = AW'(1) << (SHIFT - 1);
         localparam logic signed [RW-1:0] YMAX = RW'((2 ** (SAMPLE_WIDTH - 1)) - 1);
         localparam logic signed [RW-1:0] YMIN = RW'(-(2 ** (SAMPLE_WIDTH - 1)));

         sample_type x1_ff, x2_ff, y1_ff, y2_ff;
         sample_type xin_ff;
         logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
         logic calc_ff;
         logic calc_in;
         logic signed [AW-1:0] acc;
         logic signed [AW-1:0] rnd;
         logic signed [RW-1:0] scaled;
         sample_type y;

         // sum at full width, round half up, saturate
         always_comb begin
            acc = AW'(p0_ff) + AW'(p1_ff) + AW'(p2_ff) + AW'(p3_ff) + AW'(p4_ff);
            rnd = acc + $signed(ROUND);
            scaled = rnd[AW-1:SHIFT];
            if (scaled > YMAX) begin
               y = YMAX[SAMPLE_WIDTH-1:0];
            end else if (scaled < YMIN) begin
               y = YMIN[SAMPLE_WIDTH-1:0];
            end else begin
               y = scaled[SAMPLE_WIDTH-1:0];
            end
         end

         always_comb begin
            calc_in       = 1'b0;
            out_in.valid  = 1'b0;
            out_in.sample = out_ff.sample;
            if (calc_ff) begin
               out_in.valid  = 1'b1;
               out_in.sample = y;
            end else if (link_in.valid) begin
               if (active) begin
                  calc_in = 1'b1;
               end else begin
                  // inactive: pass the word on, leave history alone
                  out_in = link_in;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               calc_ff <= 1'b0;
               x1_ff   <= '0;
               x2_ff   <= '0;
               y1_ff   <= '0;
               y2_ff   <= '0;
            end else begin
               calc_ff <= calc_in;
               if (calc_ff) begin
                  x2_ff <= x1_ff;
                  x1_ff <= xin_ff;
                  y2_ff <= y1_ff;
                  y1_ff <= y;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (link_in.valid && active) begin
               xin_ff <= link_in.sample;
               p0_ff  <= link_in.sample * C_B0;
               p1_ff  <= x1_ff * C_B1;
               p2_ff  <= x2_ff * C_B2;
               p3_ff  <= y1_ff * C_A1;
               p4_ff  <= y2_ff * C_A2;
            end
         end
      end else begin : g_pass
         // no coefficients for this section: pass through
         always_comb begin
            out_in = link_in;
         end
      end
   endgenerate

endmodule

/* sv/biquad_cascade_df1_filter_unit.sv */
// Each of the first N sections (N = clamped active stages) registers the products, then
// the sum/round/saturate result; an idle one registers the word as it is passed on.
// One word travels the chain at a time; req_stall holds until it has left the hold slot.
// Reset: active stages 10, all section history zero, no word in flight.
module biquad_cascade_df1_filter_unit #(
   parameter int MAX_STAGES  = 10,
   parameter int COEFF_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bqdf1_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bqdf1_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqdf1_pkg::CSR_WIDTH-1:0]     csr_data
);
   import bqdf1_pkg::*;

   localparam int NW = ($clog2(MAX_STAGES + 1) > CSR_WIDTH) ?
                       $clog2(MAX_STAGES + 1) : CSR_WIDTH;

   logic [CSR_WIDTH-1:0] stages_ff, stages_in;
   logic [NW-1:0]        n_eff;
   logic                 busy_ff, busy_in;
   logic                 blk_ff;
   logic                 hold_valid_ff, hold_valid_in;
   sample_type           hold_sample_ff;
   logic                 hold_blk_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;
   logic                 req_accept;
   logic                 rsp_load;
   logic                 chain_done;
   logic [MAX_STAGES-1:0] active;
   logic [MAX_STAGES-1:0] link_valid;
   link_type             chain [MAX_STAGES+1];

   assign req_stall  = busy_ff | hold_valid_ff;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign chain_done = chain[MAX_STAGES].valid;
   assign rsp_load   = hold_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   assign chain[0] = '{valid: req_accept, sample: req_data.sample_in};

   // zero acts as one, anything past the chain acts as the full chain
   always_comb begin
      n_eff = NW'(stages_ff);
      if (stages_ff == '0) begin
         n_eff = NW'(1);
      end else if (NW'(stages_ff) > NW'(MAX_STAGES)) begin
         n_eff = NW'(MAX_STAGES);
      end
   end

   generate
      for (genvar k = 0; k < MAX_STAGES; k++) begin : g_sec
         assign active[k]     = NW'(k) < n_eff;
         assign link_valid[k] = chain[k+1].valid;
         bqdf1_section #(
            .STAGE       (k),
            .COEFF_WIDTH (COEFF_WIDTH)
         ) u_sec (
            .clock    (clock),
            .reset    (reset),
            .active   (active[k]),
            .link_in  (chain[k]),
            .link_out (chain[k+1])
         );
      end
   endgenerate

   always_comb begin
      stages_in = stages_ff;
      if (csr_valid && csr_ready) begin
         stages_in = csr_data;
      end
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (chain_done) begin
         busy_in = 1'b0;
      end
      hold_valid_in = hold_valid_ff;
      if (chain_done) begin
         hold_valid_in = 1'b1;
      end else if (rsp_load) begin
         hold_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stages_ff     <= STAGES_RESET;
         busy_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stages_ff     <= stages_in;
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         blk_ff <= req_data.block_end;
      end
      if (chain_done) begin
         hold_sample_ff <= chain[MAX_STAGES].sample;
         hold_blk_ff    <= blk_ff;
      end
      if (rsp_load) begin
         rsp_data_ff <= '{sample_out: hold_sample_ff, block_end_out: hold_blk_ff};
      end
   end

   a_one_word_in_chain: assert property (@(posedge clock) disable iff (reset)
      $onehot0(link_valid))
      else $error("more than one word moving along the section chain");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> (busy_ff && !hold_valid_ff))
      else $error("chain result with no word in flight or hold slot full");

   a_hold_kept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && rsp_valid_ff && rsp_stall) |=> hold_valid_ff)
      else $error("held result dropped while output stalled");

endmodule
